// ----- design/shunt_bank_deadband_stepper_core_macros.svh -----
// assertion macros shared by the stepper core modules
`ifndef SHUNT_BANK_DEADBAND_STEPPER_CORE_MACROS_SVH
`define SHUNT_BANK_DEADBAND_STEPPER_CORE_MACROS_SVH

// same-cycle implication, clocked on clock, off while reset is high
`define SBDS_ASSERT_SAME(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off while reset is high
`define SBDS_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- design/sbds_pkg.sv -----
// types, constants and register map of the shunt bank stepper core
`timescale 1ns / 1ps

package sbds_pkg;

   localparam int NUM_BLOCKS   = 4;
   localparam int BLOCK_REGS   = 4;
   localparam int USED_BLOCKS  = (NUM_BLOCKS < BLOCK_REGS) ? NUM_BLOCKS : BLOCK_REGS;
   localparam int BLK_IDX_W    = (USED_BLOCKS > 1) ? $clog2(USED_BLOCKS) : 1;

   localparam int STEP_W       = 10;
   localparam int VOLT_W       = 16;
   localparam int TICK_W       = 16;
   localparam int CNT_W        = 8;
   localparam int FIELD_W      = 24;
   localparam int SUM_W        = 34;
   localparam int ACC_W        = SUM_W + $clog2(USED_BLOCKS);
   localparam int PROD_W       = CNT_W + FIELD_W + 1;

   localparam int REQ_TYPE_W   = 2;
   localparam int REQ_TDATA_W  = 24;
   localparam int RSP_TDATA_W  = 80;

   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 56;

   // block word layout
   localparam int CNT_LSB      = 0;
   localparam int B_LSB        = 8;
   localparam int G_LSB        = 32;

   localparam logic [REQ_TYPE_W-1:0] REQ_TIMED     = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_IMMEDIATE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_RESTART   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_LOW_THR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_THR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK0    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BASE      = 3'd7;

   localparam logic [VOLT_W-1:0] LOW_THR_RESET  = 16'd15892;
   localparam logic [VOLT_W-1:0] HIGH_THR_RESET = 16'd16876;

   typedef struct packed {
      logic [VOLT_W-1:0]                          low_thr;
      logic [VOLT_W-1:0]                          high_thr;
      logic [TICK_W-1:0]                          hold_ticks;
      logic [USED_BLOCKS-1:0][CNT_W-1:0]          count;
      logic [USED_BLOCKS-1:0][FIELD_W-1:0]        b_step;
      logic [USED_BLOCKS-1:0][FIELD_W-1:0]        g_step;
      logic [FIELD_W-1:0]                         base_b;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic walk;
      logic sum_start;
      logic sum_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic is_restart;
      logic walk_done;
      logic sum_last;
   } status_type;

endpackage

// ----- design/shunt_bank_deadband_stepper_core.sv -----
// top level of the switched shunt bank deadband stepper
`timescale 1ns / 1ps
// Switched shunt bank controller. Each request on the req_ stream carries one
// bus voltage sample (tdata) and a request kind (tuser: timed tick, immediate
// adjustment or restart). Each request yields exactly one response on the
// rsp_ stream: the bank step, a changed flag and the saturated conductance and
// susceptance sums at that step.
// Registers are written on the csr_ channel (always ready); writing them only
// while no request is in progress is up to the user, not enforced by the block.
// A timed or immediate request passes through the start, sum and finish states
// before its response is valid, and a new request can be accepted once the
// block is back in idle; the sum runs over one block a cycle. A restart first
// walks the steps, one step or block change a cycle, until the susceptance sum
// reaches the base or the top step.
// A finished response waits in the output register; the next request is
// accepted and worked on meanwhile, and stalls only at its own completion.
// Reset clears the step, hold counter and switched flag, loads register
// defaults, and drops rsp_tvalid.

module shunt_bank_deadband_stepper_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sbds_pkg::REQ_TDATA_W-1:0]    req_tdata,  // voltage[15:0], active[16], zero pad
   input  logic [sbds_pkg::REQ_TYPE_W-1:0]     req_tuser,  // req_type[1:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sbds_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // step[9:0], changed[10],
                                                           // effective_g[44:11],
                                                           // effective_b[78:45], zero pad
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sbds_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sbds_pkg::CSR_DATA_W-1:0]     csr_data
);
   import sbds_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   sbds_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sbds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sbds_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ----- design/sbds_csr.sv -----
// configuration registers written through the csr channel
`timescale 1ns / 1ps

module sbds_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sbds_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sbds_pkg::CSR_DATA_W-1:0]   csr_data,
   output sbds_pkg::cfg_type                 cfg
);
   import sbds_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_LOW_THR:  cfg_in.low_thr    = csr_data[VOLT_W-1:0];
            REG_HIGH_THR: cfg_in.high_thr   = csr_data[VOLT_W-1:0];
            REG_HOLD:     cfg_in.hold_ticks = csr_data[TICK_W-1:0];
            REG_BASE:     cfg_in.base_b     = csr_data[FIELD_W-1:0];
            default: begin
               // block words; those beyond the used blocks are dropped
               for (int k = 0; k < USED_BLOCKS; k++) begin
                  if (csr_index == REG_BLOCK0 + CSR_IDX_W'(k)) begin
                     cfg_in.count[k]  = csr_data[CNT_LSB +: CNT_W];
                     cfg_in.b_step[k] = csr_data[B_LSB +: FIELD_W];
                     cfg_in.g_step[k] = csr_data[G_LSB +: FIELD_W];
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{low_thr: LOW_THR_RESET, high_thr: HIGH_THR_RESET, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- design/sbds_ctrl.sv -----
// sequencing state machine and response valid
`timescale 1ns / 1ps
`include "shunt_bank_deadband_stepper_core_macros.svh"

module sbds_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  sbds_pkg::status_type  status,
   output sbds_pkg::cmd_type     cmd
);
   import sbds_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_WALK   = 3'd1;
   localparam logic [2:0] ST_START  = 3'd2;
   localparam logic [2:0] ST_SUM    = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = status.is_restart ? ST_WALK : ST_START;
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_done) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.sum_start = 1'b1;
            state_in      = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            if (status.sum_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait here while the previous response is still held
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `SBDS_ASSERT_SAME(a_no_overwrite, cmd.out_load, !rsp_valid_ff || rsp_tready, "response overwritten while held")
   `SBDS_ASSERT_NEXT(a_busy_after_accept, accept, state_ff != ST_IDLE, "request accepted with no work started")
   `SBDS_ASSERT_SAME(a_rsp_from_finish, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH, "response raised outside finish")

endmodule

// ----- design/sbds_dp.sv -----
// step state, restart walk, block sums and response register
`timescale 1ns / 1ps
`include "shunt_bank_deadband_stepper_core_macros.svh"

module sbds_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  sbds_pkg::cfg_type                   cfg,
   input  sbds_pkg::cmd_type                   cmd,
   output sbds_pkg::status_type                status,
   input  logic [sbds_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [sbds_pkg::REQ_TYPE_W-1:0]     req_tuser,
   output logic [sbds_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import sbds_pkg::*;

   function automatic logic [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      logic [SUM_W-1:0]        r;
      hi = {{(ACC_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
      lo = {{(ACC_W-SUM_W+1){1'b1}}, {(SUM_W-1){1'b0}}};
      if (a > hi) begin
         r = hi[SUM_W-1:0];
      end else if (a < lo) begin
         r = lo[SUM_W-1:0];
      end else begin
         r = a[SUM_W-1:0];
      end
      return r;
   endfunction

   logic [STEP_W-1:0]          bank_step_ff, bank_step_in;
   logic [TICK_W-1:0]          ticks_ff, ticks_in;
   logic                       has_sw_ff, has_sw_in;
   logic [STEP_W-1:0]          before_ff, before_in;
   logic [STEP_W-1:0]          walk_s_ff, walk_s_in;
   logic [CNT_W-1:0]           walk_j_ff, walk_j_in;
   logic [BLK_IDX_W-1:0]       blk_ff, blk_in;
   logic [STEP_W-1:0]          left_ff, left_in;
   logic signed [ACC_W-1:0]    acc_g_ff, acc_g_in;
   logic signed [ACC_W-1:0]    acc_b_ff, acc_b_in;
   logic [RSP_TDATA_W-1:0]     rsp_data_ff, rsp_data_in;

   logic [VOLT_W-1:0]          voltage;
   logic                       active;
   logic [STEP_W-1:0]          max_step;
   logic                       step_up;
   logic                       step_dn;
   logic [STEP_W:0]            cand;
   logic [STEP_W-1:0]          vstep;
   logic [TICK_W-1:0]          ticks_inc;
   logic                       hold_ok;
   logic [CNT_W-1:0]           cur_cnt;
   logic [FIELD_W-1:0]         cur_b;
   logic [FIELD_W-1:0]         cur_g;
   logic signed [ACC_W-1:0]    base_ext;
   logic signed [ACC_W-1:0]    cur_b_ext;
   logic                       walk_done;
   logic [CNT_W-1:0]           sel;
   logic signed [PROD_W-1:0]   prod_g;
   logic signed [PROD_W-1:0]   prod_b;
   logic [BLK_IDX_W-1:0]       blk_next;

   assign voltage = req_tdata[VOLT_W-1:0];
   assign active  = req_tdata[VOLT_W];

   always_comb begin
      max_step = '0;
      for (int k = 0; k < USED_BLOCKS; k++) begin
         max_step = max_step + STEP_W'(cfg.count[k]);
      end
   end

   // deadband step, clamped only when a step is taken
   always_comb begin
      step_up = voltage < cfg.low_thr;
      step_dn = voltage > cfg.high_thr;
      cand    = {1'b0, bank_step_ff};
      if (step_up) begin
         cand = {1'b0, bank_step_ff} + 1'b1;
      end else if (step_dn) begin
         cand = (bank_step_ff == '0) ? '0 : {1'b0, bank_step_ff} - 1'b1;
      end
      if (cand > {1'b0, max_step}) begin
         cand = {1'b0, max_step};
      end
      vstep = (step_up || step_dn) ? cand[STEP_W-1:0] : bank_step_ff;
   end

   assign ticks_inc = (ticks_ff == '1) ? ticks_ff : ticks_ff + 1'b1;
   assign hold_ok   = !has_sw_ff || (ticks_inc >= cfg.hold_ticks);

   assign cur_cnt   = cfg.count[blk_ff];
   assign cur_b     = cfg.b_step[blk_ff];
   assign cur_g     = cfg.g_step[blk_ff];
   assign base_ext  = {{(ACC_W-FIELD_W){cfg.base_b[FIELD_W-1]}}, cfg.base_b};
   assign cur_b_ext = {{(ACC_W-FIELD_W){cur_b[FIELD_W-1]}}, cur_b};
   assign walk_done = (acc_b_ff >= base_ext) || (walk_s_ff == max_step);
   assign blk_next  = (blk_ff == BLK_IDX_W'(USED_BLOCKS - 1)) ? '0 : blk_ff + 1'b1;

   assign sel    = (left_ff < {{(STEP_W-CNT_W){1'b0}}, cur_cnt}) ? left_ff[CNT_W-1:0] : cur_cnt;
   assign prod_g = $signed({1'b0, sel}) * $signed(cur_g);
   assign prod_b = $signed({1'b0, sel}) * $signed(cur_b);

   assign status.is_restart = (req_tuser == REQ_RESTART);
   assign status.walk_done  = walk_done;
   assign status.sum_last   = (blk_ff == BLK_IDX_W'(USED_BLOCKS - 1));

   always_comb begin
      bank_step_in = bank_step_ff;
      ticks_in     = ticks_ff;
      has_sw_in    = has_sw_ff;
      before_in    = before_ff;
      walk_s_in    = walk_s_ff;
      walk_j_in    = walk_j_ff;
      blk_in       = blk_ff;
      left_in      = left_ff;
      acc_g_in     = acc_g_ff;
      acc_b_in     = acc_b_ff;
      rsp_data_in  = rsp_data_ff;

      if (cmd.load) begin
         before_in = bank_step_ff;
         unique case (req_tuser)
            REQ_TIMED: begin
               ticks_in = ticks_inc;
               if (active && hold_ok) begin
                  bank_step_in = vstep;
                  if (vstep != bank_step_ff) begin
                     has_sw_in = 1'b1;
                     ticks_in  = '0;
                  end
               end
            end
            REQ_IMMEDIATE: begin
               if (active) begin
                  bank_step_in = vstep;
               end
            end
            REQ_RESTART: begin
               has_sw_in = 1'b0;
               ticks_in  = '0;
               walk_s_in = '0;
               walk_j_in = '0;
               blk_in    = '0;
               acc_b_in  = '0;
            end
            default: ;
         endcase
      end

      // walk one step or one block change a cycle until the susceptance sum reaches the base or the top step
      if (cmd.walk) begin
         if (walk_done) begin
            bank_step_in = walk_s_ff;
         end else if (walk_j_ff == cur_cnt) begin
            blk_in    = blk_next;
            walk_j_in = '0;
         end else begin
            acc_b_in  = acc_b_ff + cur_b_ext;
            walk_s_in = walk_s_ff + 1'b1;
            walk_j_in = walk_j_ff + 1'b1;
         end
      end

      if (cmd.sum_start) begin
         left_in  = bank_step_ff;
         blk_in   = '0;
         acc_g_in = '0;
         acc_b_in = '0;
      end

      // blocks fill in order, one block a cycle
      if (cmd.sum_step) begin
         acc_g_in = acc_g_ff + {{(ACC_W-PROD_W){prod_g[PROD_W-1]}}, prod_g};
         acc_b_in = acc_b_ff + {{(ACC_W-PROD_W){prod_b[PROD_W-1]}}, prod_b};
         left_in  = left_ff - {{(STEP_W-CNT_W){1'b0}}, sel};
         blk_in   = blk_next;
      end

      if (cmd.out_load) begin
         rsp_data_in = {1'b0, sat_sum(acc_b_ff), sat_sum(acc_g_ff),
                        (bank_step_ff != before_ff), bank_step_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_step_ff <= '0;
         ticks_ff     <= '0;
         has_sw_ff    <= 1'b0;
      end else begin
         bank_step_ff <= bank_step_in;
         ticks_ff     <= ticks_in;
         has_sw_ff    <= has_sw_in;
      end
   end

   always_ff @(posedge clock) begin
      before_ff   <= before_in;
      walk_s_ff   <= walk_s_in;
      walk_j_ff   <= walk_j_in;
      blk_ff      <= blk_in;
      left_ff     <= left_in;
      acc_g_ff    <= acc_g_in;
      acc_b_ff    <= acc_b_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tdata = rsp_data_ff;

   `SBDS_ASSERT_SAME(a_walk_in_range, cmd.walk, walk_s_ff <= max_step, "restart walk beyond top step")
   `SBDS_ASSERT_NEXT(a_walk_commit_range, cmd.walk && walk_done, bank_step_ff <= max_step, "restart step beyond top step")
   `SBDS_ASSERT_NEXT(a_vstep_range, cmd.load && !status.is_restart, (bank_step_ff == $past(bank_step_ff)) || (bank_step_ff <= max_step), "voltage step left the clamp range")

endmodule

// ----- dv/shunt_bank_deadband_stepper_core_tb.sv -----
// self-checking testbench for the shunt bank deadband stepper core
`timescale 1ns / 1ps

module shunt_bank_deadband_stepper_core_tb;
   import sbds_pkg::*;

   localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam longint SUM_TOP    = 64'sd8589934591;
   localparam longint SUM_BOTTOM = -64'sd8589934592;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int NUM_PHASES      = 13;
   localparam int PHASE_REQUESTS  = 102;
   localparam int NUM_PLAN        = 32;

   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic              changed;
      logic [SUM_W-1:0]  g;
      logic [SUM_W-1:0]  b;
   } bank_result_type;

   typedef struct packed {
      logic            typed;
      bank_result_type val;
   } typed_check_type;

   typedef struct packed {
      logic [VOLT_W-1:0]                     low_v;
      logic [VOLT_W-1:0]                     high_v;
      logic [TICK_W-1:0]                     hold;
      logic [BLOCK_REGS-1:0][CSR_DATA_W-1:0] blk;
      logic [FIELD_W-1:0]                    base;
   } bank_setting_type;

   typedef enum logic [1:0] {ROW_CHECK, ROW_TYPED, ROW_REG} plan_kind_type;

   typedef struct packed {
      plan_kind_type           kind;
      logic [CSR_IDX_W-1:0]    code;   // request kind or register index
      logic [CSR_DATA_W-1:0]   value;  // voltage or register data
      logic                    act;
      bank_result_type         typed;
   } plan_row_type;

   localparam bank_result_type RESULT_ZERO = '0;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata = '0;
   logic [REQ_TYPE_W-1:0]    req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   // predictor copy of the bank
   bank_setting_type         live_cfg;
   logic [STEP_W-1:0]        live_step;
   logic [TICK_W-1:0]        live_ticks;
   logic                     live_switched;

   bank_result_type          pending_bank_results[$];
   typed_check_type          typed_checks[$];

   bit                       quiet = 1'b0;
   bit                       rsp_hold_pending = 1'b0;
   int unsigned              mismatch_count = 0;
   int unsigned              kind_count[4] = '{0, 0, 0, 0};
   int unsigned              change_count = 0;
   int unsigned              reg_write_count = 0;
   int unsigned              setting_count = 0;
   int unsigned              top_step_seen = 0;

   plan_row_type directed_plan [NUM_PLAN] = '{
      // empty bank after reset: every response is all zeros
      '{ROW_TYPED, 3'(REQ_TIMED),     56'h0,    1'b1, RESULT_ZERO},
      '{ROW_TYPED, 3'(REQ_TIMED),     56'hFFFF, 1'b1, RESULT_ZERO},
      '{ROW_TYPED, 3'(REQ_IMMEDIATE), 56'h0,    1'b1, RESULT_ZERO},
      '{ROW_TYPED, 3'(REQ_IMMEDIATE), 56'hFFFF, 1'b0, RESULT_ZERO},
      '{ROW_TYPED, 3'(REQ_RESTART),   56'h0,    1'b0, RESULT_ZERO},
      '{ROW_TYPED, 3'(REQ_UNUSED),    56'hFFFF, 1'b1, RESULT_ZERO},
      '{ROW_REG, REG_LOW_THR,  56'd16000, 1'b0, RESULT_ZERO},
      '{ROW_REG, REG_HIGH_THR, 56'd16800, 1'b0, RESULT_ZERO},
      '{ROW_REG, REG_HOLD,     56'd2,     1'b0, RESULT_ZERO},
      '{ROW_REG, REG_BLOCK0,        {24'h000800, 24'h010000, 8'd2},   1'b0, RESULT_ZERO},
      '{ROW_REG, REG_BLOCK0 + 3'd1, {24'h800000, 24'h7FFFFF, 8'd255}, 1'b0, RESULT_ZERO},
      '{ROW_REG, REG_BLOCK0 + 3'd2, {24'h123456, 24'hFEDCBA, 8'd0},   1'b0, RESULT_ZERO},
      '{ROW_REG, REG_BLOCK0 + 3'd3, {24'h7FFFFF, 24'h800000, 8'd1},   1'b0, RESULT_ZERO},
      '{ROW_REG, REG_BASE,     56'h020000, 1'b0, RESULT_ZERO},
      // first timed switch, then the hold, then a switch once it expires
      '{ROW_CHECK, 3'(REQ_TIMED),     56'h0,     1'b1, RESULT_ZERO},
      '{ROW_CHECK, 3'(REQ_TIMED),     56'h0,     1'b1, RESULT_ZERO},
      '{ROW_CHECK, 3'(REQ_TIMED),     56'h0,     1'b1, RESULT_ZERO},
      // voltages sitting exactly on the thresholds, then one unit outside
      '{ROW_CHECK, 3'(REQ_IMMEDIATE), 56'd16000, 1'b1, RESULT_ZERO},
      '{ROW_CHECK, 3'(REQ_IMMEDIATE), 56'd16800, 1'b1, RESULT_ZERO},
      '{ROW_CHECK, 3'(REQ_IMMEDIATE), 56'd15999, 1'b1, RESULT_ZERO},
      '{ROW_CHECK, 3'(REQ_IMMEDIATE), 56'd16801, 1'b1, RESULT_ZERO},
      '{ROW_CHECK, 3'(REQ_TIMED),     56'hFFFF,  1'b0, RESULT_ZERO},
      '{ROW_CHECK, 3'(REQ_TIMED),     56'hFFFF,  1'b1, RESULT_ZERO},
      '{ROW_CHECK, 3'(REQ_RESTART),   56'h0,     1'b0, RESULT_ZERO},
      '{ROW_CHECK, 3'(REQ_UNUSED),    56'h0,     1'b1, RESULT_ZERO},
      // shrink the bank under the current step
      '{ROW_REG, REG_BLOCK0,        {24'h000800, 24'h010000, 8'd1}, 1'b0, RESULT_ZERO},
      '{ROW_REG, REG_BLOCK0 + 3'd1, {24'h800000, 24'h7FFFFF, 8'd0}, 1'b0, RESULT_ZERO},
      '{ROW_REG, REG_BLOCK0 + 3'd3, {24'h7FFFFF, 24'h800000, 8'd0}, 1'b0, RESULT_ZERO},
      '{ROW_CHECK, 3'(REQ_IMMEDIATE), 56'h0,     1'b1, RESULT_ZERO},
      '{ROW_REG, REG_BASE,     56'h800000, 1'b0, RESULT_ZERO},
      '{ROW_CHECK, 3'(REQ_RESTART),   56'hFFFF,  1'b1, RESULT_ZERO},
      '{ROW_CHECK, 3'(REQ_IMMEDIATE), 56'h0,     1'b1, RESULT_ZERO}
   };

   shunt_bank_deadband_stepper_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------- predictor ----------------

   function automatic int unsigned bank_top();
      int unsigned total;
      int k;
      total = 0;
      for (k = 0; k < USED_BLOCKS; k++)
         total += live_cfg.blk[k][CNT_LSB +: CNT_W];
      return total;
   endfunction

   // blocks fill in order; each contributes min(left, count) steps
   function automatic longint bank_sum(int unsigned at_step, bit conductance);
      longint acc, per;
      int unsigned left, cnt, take;
      int k;
      acc = 0;
      left = at_step;
      for (k = 0; k < USED_BLOCKS; k++) begin
         cnt = live_cfg.blk[k][CNT_LSB +: CNT_W];
         take = (left < cnt) ? left : cnt;
         per = conductance ? longint'($signed(live_cfg.blk[k][G_LSB +: FIELD_W]))
                           : longint'($signed(live_cfg.blk[k][B_LSB +: FIELD_W]));
         acc += longint'(take) * per;
         left -= take;
      end
      if (acc > SUM_TOP) acc = SUM_TOP;
      if (acc < SUM_BOTTOM) acc = SUM_BOTTOM;
      return acc;
   endfunction

   function automatic int unsigned restart_target();
      int unsigned top, s;
      longint base;
      top = bank_top();
      base = longint'($signed(live_cfg.base));
      for (s = 0; s <= top; s++)
         if (bank_sum(s, 1'b0) >= base) return s;
      return top;
   endfunction

   function automatic void nudge_step(logic [VOLT_W-1:0] volts);
      int nxt, top;
      nxt = int'(live_step);
      top = int'(bank_top());
      if (volts < live_cfg.low_v) nxt++;
      else if (volts > live_cfg.high_v) nxt--;
      else return;
      if (nxt < 0) nxt = 0;
      if (nxt > top) nxt = top;
      live_step = STEP_W'(nxt);
   endfunction

   function automatic bank_result_type predict_bank_result(logic [REQ_TYPE_W-1:0] kind,
                                                           logic [VOLT_W-1:0] volts,
                                                           logic act);
      bank_result_type r;
      logic [STEP_W-1:0] prior;
      prior = live_step;
      case (kind)
         REQ_TIMED: begin
            // time passes even when inactive, before the hold check
            if (live_ticks != '1) live_ticks++;
            if (act && (!live_switched || live_ticks >= live_cfg.hold)) begin
               nudge_step(volts);
               if (live_step != prior) begin
                  live_switched = 1'b1;
                  live_ticks = '0;
               end
            end
         end
         REQ_IMMEDIATE: begin
            if (act) nudge_step(volts);
         end
         REQ_RESTART: begin
            live_step = STEP_W'(restart_target());
            live_switched = 1'b0;
            live_ticks = '0;
         end
         default: ;
      endcase
      r.step = live_step;
      r.changed = (live_step != prior);
      r.g = SUM_W'(bank_sum(live_step, 1'b1));
      r.b = SUM_W'(bank_sum(live_step, 1'b0));
      return r;
   endfunction

   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         REG_LOW_THR:  live_cfg.low_v = val[VOLT_W-1:0];
         REG_HIGH_THR: live_cfg.high_v = val[VOLT_W-1:0];
         REG_HOLD:     live_cfg.hold = val[TICK_W-1:0];
         REG_BASE:     live_cfg.base = val[FIELD_W-1:0];
         default: begin
            if (idx >= REG_BLOCK0 && idx < REG_BLOCK0 + BLOCK_REGS)
               live_cfg.blk[idx - REG_BLOCK0] = val;
         end
      endcase
   endfunction

   // ---------------- monitor and scoreboard ----------------

   always @(posedge clock) begin
      bank_result_type want, got;
      typed_check_type tc;
      if (reset) begin
         live_cfg.low_v = LOW_THR_RESET;
         live_cfg.high_v = HIGH_THR_RESET;
         live_cfg.hold = '0;
         live_cfg.blk = '0;
         live_cfg.base = '0;
         live_step = '0;
         live_ticks = '0;
         live_switched = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            apply_reg(csr_index, csr_data);
            reg_write_count++;
         end
         if (req_tvalid && req_tready) begin
            want = predict_bank_result(req_tuser, req_tdata[VOLT_W-1:0], req_tdata[VOLT_W]);
            tc = (typed_checks.size() != 0) ? typed_checks.pop_front() : '0;
            if (tc.typed) want = tc.val;
            pending_bank_results.push_back(want);
            kind_count[req_tuser]++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.step = rsp_tdata[9:0];
            got.changed = rsp_tdata[10];
            got.g = rsp_tdata[44:11];
            got.b = rsp_tdata[78:45];
            if (pending_bank_results.size() == 0) begin
               $error("response with no request outstanding: step %0d", got.step);
               mismatch_count++;
            end else begin
               want = pending_bank_results.pop_front();
               if (got.step !== want.step) begin
                  $error("step: expected %0d, got %0d", want.step, got.step);
                  mismatch_count++;
               end
               if (got.changed !== want.changed) begin
                  $error("changed: expected %0b, got %0b", want.changed, got.changed);
                  mismatch_count++;
               end
               if (got.g !== want.g) begin
                  $error("effective_g: expected %0d, got %0d", $signed(want.g), $signed(got.g));
                  mismatch_count++;
               end
               if (got.b !== want.b) begin
                  $error("effective_b: expected %0d, got %0d", $signed(want.b), $signed(got.b));
                  mismatch_count++;
               end
               if (got.changed === 1'b1) change_count++;
               if (got.step > top_step_seen) top_step_seen = got.step;
            end
         end
      end
   end

   // ---------------- response side ----------------

   initial begin : rsp_sink
      int span;
      forever begin
         @(posedge clock);
         if (rsp_hold_pending) begin
            rsp_hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            span = HOLD_OFF_CYCLES;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            span = $urandom_range(1, 19);
         end else begin
            rsp_tready <= 1'b1;
            span = $urandom_range(1, 40);
         end
         repeat (span - 1) @(posedge clock);
      end
   end

   // ---------------- request side ----------------

   task automatic offer_request(input logic [REQ_TYPE_W-1:0] kind, input logic [VOLT_W-1:0] volts,
                                input logic act, input logic typed,
                                input bank_result_type typed_val);
      bit taken;
      typed_checks.push_back('{typed, typed_val});
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'd0, act, volts};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // stop offering and wait for every outstanding response
   task automatic settle_bank();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_bank_results.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic program_bank(input bank_setting_type s);
      int k;
      write_reg(REG_LOW_THR, CSR_DATA_W'(s.low_v));
      write_reg(REG_HIGH_THR, CSR_DATA_W'(s.high_v));
      write_reg(REG_HOLD, CSR_DATA_W'(s.hold));
      for (k = 0; k < BLOCK_REGS; k++)
         write_reg(REG_BLOCK0 + CSR_IDX_W'(k), s.blk[k]);
      write_reg(REG_BASE, CSR_DATA_W'(s.base));
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   task automatic pause_sender(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic bank_setting_type draw_setting();
      bank_setting_type s;
      int k;
      case ($urandom_range(0, 5))
         0: begin s.low_v = '0; s.high_v = '1; end       // deadband covers everything
         1: begin s.low_v = '1; s.high_v = '0; end       // inverted band
         default: begin
            s.low_v = VOLT_W'(16384 - $urandom_range(0, 1500));
            s.high_v = VOLT_W'(16384 + $urandom_range(0, 1500));
         end
      endcase
      case ($urandom_range(0, 4))
         0: s.hold = '0;
         1: s.hold = '1;
         default: s.hold = TICK_W'($urandom_range(1, 6));
      endcase
      for (k = 0; k < BLOCK_REGS; k++)
         s.blk[k] = {24'($urandom), 24'($urandom), 8'($urandom_range(0, 6))};
      case ($urandom_range(0, 4))
         0: s.base = 24'h7FFFFF;
         1: s.base = 24'h800000;
         default: s.base = 24'($urandom);
      endcase
      return s;
   endfunction

   function automatic logic [VOLT_W-1:0] pick_voltage(bank_setting_type s, int bias);
      int r;
      r = $urandom_range(0, 99);
      if (r < bias)
         return (s.low_v == 0) ? VOLT_W'($urandom) : VOLT_W'($urandom_range(0, s.low_v - 1));
      if (r < bias + 25)
         return (s.high_v == '1) ? VOLT_W'($urandom) : VOLT_W'($urandom_range(s.high_v + 1, 65535));
      if (r < bias + 40)
         return $urandom_range(0, 1) ? s.low_v : s.high_v;
      return VOLT_W'($urandom);
   endfunction

   function automatic logic [REQ_TYPE_W-1:0] draw_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return REQ_TIMED;
      if (r < 87) return REQ_IMMEDIATE;
      if (r < 95) return REQ_RESTART;
      return REQ_UNUSED;
   endfunction

   task automatic offer_random(input bank_setting_type s, input int bias);
      offer_request(draw_kind(), pick_voltage(s, bias), $urandom_range(0, 9) != 0,
                    1'b0, RESULT_ZERO);
   endtask

   initial begin : stimulus
      plan_row_type row;
      bank_setting_type setting;
      int r, phase, n, bias, k;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (r = 0; r < NUM_PLAN; r++) begin
         row = directed_plan[r];
         if (row.kind == ROW_REG) begin
            if (r == 0 || directed_plan[r-1].kind != ROW_REG) settle_bank();
            write_reg(row.code, row.value);
            if (r == NUM_PLAN - 1 || directed_plan[r+1].kind != ROW_REG) csr_valid <= 1'b0;
         end else begin
            offer_request(row.code[REQ_TYPE_W-1:0], row.value[VOLT_W-1:0], row.act,
                          row.kind == ROW_TYPED, row.typed);
         end
      end
      setting_count += 3;

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         settle_bank();
         bias = $urandom_range(15, 50);
         case (phase)
            0: begin
               // full bank, falling susceptance: restart runs to the top step
               setting.low_v = 16'd16000;
               setting.high_v = 16'd16700;
               setting.hold = '0;
               for (k = 0; k < BLOCK_REGS; k++)
                  setting.blk[k] = {24'h7FFFFF, 24'h800000, 8'd255};
               setting.base = 24'h7FFFFF;
            end
            1: begin
               // full bank, rising susceptance: restart lands on step zero, then climb
               setting.low_v = 16'd16000;
               setting.high_v = 16'd16700;
               setting.hold = '0;
               for (k = 0; k < BLOCK_REGS; k++)
                  setting.blk[k] = {24'h800000, 24'h7FFFFF, 8'd255};
               setting.base = 24'h800000;
               bias = 75;
            end
            default: setting = draw_setting();
         endcase
         program_bank(setting);
         quiet = (phase == NUM_PHASES - 1);

         if (phase == 3) begin
            // keep offering while the response side is held off
            rsp_hold_pending = 1'b1;
            repeat (24) offer_random(setting, bias);
         end

         for (n = 0; n < PHASE_REQUESTS; n++) begin
            if (!quiet && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 19));
            offer_random(setting, bias);
         end
      end

      settle_bank();
      repeat (16) @(posedge clock);

      $display("covered %0d timed, %0d immediate, %0d restart, %0d unused-code requests;",
               kind_count[REQ_TIMED], kind_count[REQ_IMMEDIATE], kind_count[REQ_RESTART],
               kind_count[REQ_UNUSED]);
      $display("%0d step changes, highest step %0d, %0d register writes over %0d settings",
               change_count, top_step_seen, reg_write_count, setting_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
